>>> hdl/psil_pkg.sv
// Shared types and constants for the polyline segment lookup.
package psil_pkg;

	localparam int MAX_POINTS = 256;
	localparam int ADDR_W     = $clog2(MAX_POINTS);
	localparam int PTS_W      = 9;
	localparam int CNT_W      = (ADDR_W + 1 > PTS_W) ? ADDR_W + 1 : PTS_W;
	localparam int IDX_W      = 8;
	localparam int COORD_W    = 17;
	localparam int XY_W       = 32;
	localparam int POS_W      = 18;
	localparam int SEGNO_W    = 8;
	localparam int FRAC_W     = 24;
	localparam int NUM_W      = POS_W + 1;
	localparam int DEN_W      = COORD_W + 1;
	localparam int NMAG_W     = POS_W;
	localparam int DMAG_W     = COORD_W;
	localparam int FRAC_SH    = 16;
	localparam int QUOT_W     = NMAG_W + FRAC_SH;
	localparam int STEP_W     = $clog2(QUOT_W + 1);
	localparam int ENTRY_W    = COORD_W + 2 * XY_W;

	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_START,
		ST_DIV,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic [COORD_W-1:0] coord;
		logic [XY_W-1:0]    x;
		logic [XY_W-1:0]    y;
	} entry_t;

	typedef struct packed {
		logic              start;
		logic [NMAG_W-1:0] num_mag;
		logic [DMAG_W-1:0] den_mag;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [QUOT_W-1:0] quot;
	} div_rsp_t;

endpackage

>>> hdl/polyline_segment_interpolation_lookup.sv
// Top level: polyline vertex table, segment search and interpolation weight.
//
//  channel  | handshake                   | payload
//  item     | item_valid / item_stall     | func, entry_index, entry_coord, entry_x,
//           |                             | entry_y, query_position
//  result   | result_valid / result_stall | first_x, first_y, second_x, second_y,
//           |                             | segment_number, fraction, degenerate
//  config   | cfg_wr_en                   | cfg_wr_data (points_in_use)
//
// A load writes the entry RAM at acceptance.
// A query scans from entry 0 up to the chosen segment end i, then passes through a
// setup state (ST_START), the divider (34 quotient bits) and a result state (ST_FIN);
// a zero-length segment skips the divider.
// No item is taken while a query is in flight; a stalled result holds in place.
// Reset sets points_in_use to 2; the table contents are left as they are.
module polyline_segment_interpolation_lookup (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr_en,
	input  logic [psil_pkg::PTS_W-1:0]           cfg_wr_data,
	input  logic                                 item_valid,
	output logic                                 item_stall,
	input  logic                                 func,
	input  logic [psil_pkg::IDX_W-1:0]           entry_index,
	input  logic [psil_pkg::COORD_W-1:0]         entry_coord,
	input  logic signed [psil_pkg::XY_W-1:0]     entry_x,
	input  logic signed [psil_pkg::XY_W-1:0]     entry_y,
	input  logic signed [psil_pkg::POS_W-1:0]    query_position,
	output logic                                 result_valid,
	input  logic                                 result_stall,
	output logic signed [psil_pkg::XY_W-1:0]     first_x,
	output logic signed [psil_pkg::XY_W-1:0]     first_y,
	output logic signed [psil_pkg::XY_W-1:0]     second_x,
	output logic signed [psil_pkg::XY_W-1:0]     second_y,
	output logic [psil_pkg::SEGNO_W-1:0]         segment_number,
	output logic signed [psil_pkg::FRAC_W-1:0]   fraction,
	output logic                                 degenerate
);

	psil_pkg::state_t                 state_q, state_nxt;
	logic [psil_pkg::PTS_W-1:0]       pts_q;
	logic [psil_pkg::CNT_W-1:0]       n_ext, n_clamp;
	logic [psil_pkg::ADDR_W-1:0]      last_idx;

	logic                             accept;
	logic                             ram_we, ram_re;
	logic [psil_pkg::ADDR_W-1:0]      ram_waddr;
	psil_pkg::entry_t                 ram_wdata, ram_rdata;

	logic signed [psil_pkg::POS_W-1:0] u_q;
	logic [psil_pkg::ADDR_W-1:0]      last_q;
	logic [psil_pkg::ADDR_W-1:0]      addr_q;
	logic [psil_pkg::ADDR_W-1:0]      ridx_q;
	logic                             rdv_q;
	logic [psil_pkg::ADDR_W-1:0]      seg_q;
	psil_pkg::entry_t                 prev_q, curr_q;
	logic                             hit;

	logic signed [psil_pkg::NUM_W-1:0] num;
	logic signed [psil_pkg::DEN_W-1:0] den;
	logic [psil_pkg::NUM_W-1:0]       num_abs;
	logic [psil_pkg::DEN_W-1:0]       den_abs;
	logic                             den_zero;
	logic                             neg_q, degen_q;

	psil_pkg::div_req_t               div_req;
	psil_pkg::div_rsp_t               div_rsp;
	logic [psil_pkg::QUOT_W-1:0]      quot_q;
	logic [psil_pkg::FRAC_W-1:0]      frac_sat;
	logic                             fin_go;

	// register and count clamp
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pts_q <= psil_pkg::PTS_W'(2);
		end else if (cfg_wr_en) begin
			pts_q <= cfg_wr_data;
		end
	end

	always_comb begin
		n_ext = psil_pkg::CNT_W'(pts_q);
		if (n_ext < psil_pkg::CNT_W'(2)) begin
			n_clamp = psil_pkg::CNT_W'(2);
		end else if (n_ext > psil_pkg::CNT_W'(psil_pkg::MAX_POINTS)) begin
			n_clamp = psil_pkg::CNT_W'(psil_pkg::MAX_POINTS);
		end else begin
			n_clamp = n_ext;
		end
		last_idx = psil_pkg::ADDR_W'(n_clamp - psil_pkg::CNT_W'(1));
	end

	// entry RAM
	assign accept    = item_valid && !item_stall;
	assign ram_we    = accept && (func == psil_pkg::FUNC_LOAD) &&
	                   (32'(entry_index) < 32'(psil_pkg::MAX_POINTS));
	assign ram_waddr = psil_pkg::ADDR_W'(entry_index);
	assign ram_wdata = '{coord: entry_coord, x: entry_x, y: entry_y};

	psil_ram #(
		.WIDTH(psil_pkg::ENTRY_W),
		.DEPTH(psil_pkg::MAX_POINTS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (addr_q),
		.rdata (ram_rdata)
	);

	assign hit = rdv_q && (ridx_q != '0) &&
	             (($signed({u_q[psil_pkg::POS_W-1], u_q}) <=
	               $signed({2'b00, ram_rdata.coord})) || (ridx_q == last_q));

	// segment length and numerator
	assign num      = $signed({u_q[psil_pkg::POS_W-1], u_q}) -
	                  $signed({2'b00, prev_q.coord});
	assign den      = $signed({1'b0, curr_q.coord}) - $signed({1'b0, prev_q.coord});
	assign num_abs  = num[psil_pkg::NUM_W-1] ? psil_pkg::NUM_W'(-num) : num;
	assign den_abs  = den[psil_pkg::DEN_W-1] ? psil_pkg::DEN_W'(-den) : den;
	assign den_zero = (den == '0);

	// state machine
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			psil_pkg::ST_IDLE: begin
				if (accept && (func == psil_pkg::FUNC_QUERY)) begin
					state_nxt = psil_pkg::ST_SCAN;
				end
			end
			psil_pkg::ST_SCAN: begin
				if (hit) begin
					state_nxt = psil_pkg::ST_START;
				end
			end
			psil_pkg::ST_START: begin
				state_nxt = den_zero ? psil_pkg::ST_FIN : psil_pkg::ST_DIV;
			end
			psil_pkg::ST_DIV: begin
				if (div_rsp.done) begin
					state_nxt = psil_pkg::ST_FIN;
				end
			end
			psil_pkg::ST_FIN: begin
				if (fin_go) begin
					state_nxt = psil_pkg::ST_IDLE;
				end
			end
			default: state_nxt = psil_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		item_stall      = (state_q != psil_pkg::ST_IDLE);
		ram_re          = (state_q == psil_pkg::ST_SCAN);
		div_req.start   = (state_q == psil_pkg::ST_START) && !den_zero;
		div_req.num_mag = num_abs[psil_pkg::NMAG_W-1:0];
		div_req.den_mag = den_abs[psil_pkg::DMAG_W-1:0];
		fin_go          = (state_q == psil_pkg::ST_FIN) && (!result_valid || !result_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= psil_pkg::ST_IDLE;
			rdv_q   <= 1'b0;
		end else begin
			state_q <= state_nxt;
			rdv_q   <= (state_q == psil_pkg::ST_SCAN) && !hit;
		end
	end

	psil_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// query datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			u_q    <= query_position;
			last_q <= last_idx;
			addr_q <= '0;
		end
		if (state_q == psil_pkg::ST_SCAN) begin
			addr_q <= addr_q + 1'b1;
			ridx_q <= addr_q;
			if (rdv_q) begin
				if (hit) begin
					curr_q <= ram_rdata;
					seg_q  <= ridx_q;
				end else begin
					prev_q <= ram_rdata;
				end
			end
		end
		if (state_q == psil_pkg::ST_START) begin
			neg_q   <= num[psil_pkg::NUM_W-1] ^ den[psil_pkg::DEN_W-1];
			degen_q <= den_zero;
		end
		if (div_rsp.done) begin
			quot_q <= div_rsp.quot;
		end
	end

	// saturate to Q7.16
	always_comb begin
		if (neg_q) begin
			if (quot_q >= psil_pkg::QUOT_W'(1) << (psil_pkg::FRAC_W - 1)) begin
				frac_sat = {1'b1, {(psil_pkg::FRAC_W-1){1'b0}}};
			end else begin
				frac_sat = psil_pkg::FRAC_W'(-quot_q);
			end
		end else begin
			if (quot_q >= psil_pkg::QUOT_W'(1) << (psil_pkg::FRAC_W - 1)) begin
				frac_sat = {1'b0, {(psil_pkg::FRAC_W-1){1'b1}}};
			end else begin
				frac_sat = quot_q[psil_pkg::FRAC_W-1:0];
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (fin_go) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			first_x        <= prev_q.x;
			first_y        <= prev_q.y;
			second_x       <= curr_q.x;
			second_y       <= curr_q.y;
			segment_number <= psil_pkg::SEGNO_W'(seg_q);
			fraction       <= degen_q ? '0 : frac_sat;
			degenerate     <= degen_q;
		end
	end

endmodule

>>> hdl/psil_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module psil_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hdl/psil_div.sv
// Restoring divider, one quotient bit per cycle, for the segment weight.
module psil_div (
	input  logic                clk,
	input  logic                arst_n,
	input  psil_pkg::div_req_t  req,
	output psil_pkg::div_rsp_t  rsp
);

	logic                            busy_q;
	logic [psil_pkg::STEP_W-1:0]     step_q;
	logic [psil_pkg::DMAG_W-1:0]     den_q;
	logic [psil_pkg::DMAG_W-1:0]     rem_q;
	logic [psil_pkg::QUOT_W-1:0]     dq_q;
	logic                            done_q;
	logic [psil_pkg::DMAG_W:0]       trial;
	logic [psil_pkg::DMAG_W+1:0]     diff;

	assign trial = {rem_q, dq_q[psil_pkg::QUOT_W-1]};
	assign diff  = {1'b0, trial} - {2'b00, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == psil_pkg::STEP_W'(psil_pkg::QUOT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			den_q <= req.den_mag;
			rem_q <= '0;
			dq_q  <= {req.num_mag, {psil_pkg::FRAC_SH{1'b0}}};
		end else if (busy_q) begin
			if (!diff[psil_pkg::DMAG_W+1]) begin
				rem_q <= diff[psil_pkg::DMAG_W-1:0];
				dq_q  <= {dq_q[psil_pkg::QUOT_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[psil_pkg::DMAG_W-1:0];
				dq_q  <= {dq_q[psil_pkg::QUOT_W-2:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = dq_q;

endmodule

>>> hdl/psil_chk.sv
// Port-level checks for the polyline segment lookup, bound to the top level.
module psil_chk (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               item_valid,
	input logic                               item_stall,
	input logic                               func,
	input logic                               result_valid,
	input logic                               result_stall,
	input logic [psil_pkg::SEGNO_W-1:0]       segment_number,
	input logic signed [psil_pkg::FRAC_W-1:0] fraction,
	input logic                               degenerate
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(fraction) &&
		$stable(segment_number))
		else $error("stalled result changed");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && degenerate |-> fraction == '0)
		else $error("degenerate segment with nonzero fraction");

	a_seg_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> segment_number != '0)
		else $error("segment number zero");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && (func == psil_pkg::FUNC_QUERY) |=> item_stall)
		else $error("item taken right after a query");

endmodule

bind polyline_segment_interpolation_lookup psil_chk u_psil_chk (.*);
